### src/tcec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcec_pkg
// Shared types and constants of the text console escape and cursor unit.
// ----------------------------------------------------------------------------
package tcec_pkg;

    localparam int GLYPH_WIDTH = 8;
    localparam int LINE_HEIGHT = 16;
    localparam int HEX_DIGITS  = 6;
    localparam int MAX_RESULTS = 6;
    localparam int QUEUE_DEPTH = 4;

    localparam int CHAR_W  = 8;
    localparam int X_W     = 13;
    localparam int Y_W     = 16;
    localparam int COLOR_W = 32;
    localparam int CNT_W   = $clog2(HEX_DIGITS + 1);
    localparam int IDX_W   = $clog2(HEX_DIGITS);
    localparam int REP_W   = $clog2(MAX_RESULTS + 1);
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [X_W-1:0]     WIDTH_RESET = X_W'(1024);
    localparam logic [COLOR_W-1:0] COLOR_RESET = '1;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NL  = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_BSL = 8'h5c;
    localparam logic [CHAR_W-1:0] CH_PCT = 8'h25;
    localparam logic [CHAR_W-1:0] CH_LBR = 8'h7b;
    localparam logic [CHAR_W-1:0] CH_RBR = 8'h7d;
    localparam logic [CHAR_W-1:0] CH_C   = 8'h43;
    localparam logic [CHAR_W-1:0] CH_QM  = 8'h3f;
    localparam logic [CHAR_W-1:0] CH_0   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UA  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF  = 8'h46;

    typedef enum logic [1:0] {
        PM_NORMAL = 2'd0,
        PM_ESCAPE = 2'd1,
        PM_HEX    = 2'd2
    } parse_mode_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_TOP,
        FS_NEXT
    } front_state_t;

    typedef enum logic [2:0] {
        CK_NONE,
        CK_NL,
        CK_CR,
        CK_DRAW,
        CK_COLOR,
        CK_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic               wrap;
        logic               advance;
        logic               report;
        logic [CHAR_W-1:0]  glyph;
        logic [COLOR_W-1:0] color;
    } cmd_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              allow_escape;
        logic              end_of_string;
    } char_word_t;

    typedef struct packed {
        logic [X_W-1:0]     pos_x;
        logic [Y_W-1:0]     pos_y;
        logic [CHAR_W-1:0]  glyph_code;
        logic [COLOR_W-1:0] draw_color;
        logic               run_last;
    } draw_word_t;

endpackage

### src/tcec_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcec_queue
// Small command queue between the parser front and the cursor back.
// ----------------------------------------------------------------------------
module tcec_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tcec_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output tcec_pkg::cmd_t head
);

    tcec_pkg::cmd_t                    mem_reg [tcec_pkg::QUEUE_DEPTH];
    logic [tcec_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [tcec_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [tcec_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;
    logic                              do_push, do_pop;

    assign full    = (cnt_reg == tcec_pkg::QCNT_W'(tcec_pkg::QUEUE_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == tcec_pkg::QPTR_W'(tcec_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == tcec_pkg::QPTR_W'(tcec_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### src/tcec_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcec_front
// Escape parser: accepts characters, classifies them and issues cursor
// commands, replaying held hex bytes when a string ends inside a colour code.
// ----------------------------------------------------------------------------
module tcec_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_stall,
    input  tcec_pkg::char_word_t char_data,
    output logic                 q_push,
    output tcec_pkg::cmd_t       q_cmd,
    input  logic                 q_full
);

    tcec_pkg::front_state_t          state_reg, state_next;
    tcec_pkg::parse_mode_t           mode_reg, mode_next;
    logic [tcec_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [tcec_pkg::CHAR_W-1:0]     hold_reg [tcec_pkg::HEX_DIGITS];
    logic [tcec_pkg::CHAR_W-1:0]     rbuf_reg [tcec_pkg::HEX_DIGITS];
    logic [tcec_pkg::CNT_W-1:0]      ridx_reg, ridx_next;
    logic [tcec_pkg::CNT_W-1:0]      rlen_reg, rlen_next;
    logic [tcec_pkg::CHAR_W-1:0]     cur_c_reg, cur_c_next;
    logic                            cur_eos_reg, cur_eos_next;
    logic                            esc_reg, esc_next;
    logic [tcec_pkg::REP_W-1:0]      rep_reg, rep_next;

    logic                            do_byte, go_top, hold_we, start_rep;
    logic [tcec_pkg::CHAR_W-1:0]     src_c;
    logic                            src_eos, src_esc;
    logic [tcec_pkg::REP_W-1:0]      rep_base;
    logic [tcec_pkg::COLOR_W-1:0]    hex_color;

    function automatic logic [3:0] hex_val(input logic [tcec_pkg::CHAR_W-1:0] c);
        logic [tcec_pkg::CHAR_W-1:0] d;
        logic [3:0]                  v;
        v = 4'd0;
        if (c >= tcec_pkg::CH_0 && c <= tcec_pkg::CH_9)
        begin
            d = c - tcec_pkg::CH_0;
            v = d[3:0];
        end
        else if (c >= tcec_pkg::CH_LA && c <= tcec_pkg::CH_LF)
        begin
            d = c - tcec_pkg::CH_LA;
            v = d[3:0] + 4'd10;
        end
        else if (c >= tcec_pkg::CH_UA && c <= tcec_pkg::CH_UF)
        begin
            d = c - tcec_pkg::CH_UA;
            v = d[3:0] + 4'd10;
        end
        return v;
    endfunction

    function automatic tcec_pkg::cmd_t draw_cmd(input logic [tcec_pkg::CHAR_W-1:0] g,
                                                input logic adv);
        tcec_pkg::cmd_t cmd;
        cmd         = '0;
        cmd.kind    = tcec_pkg::CK_DRAW;
        cmd.glyph   = g;
        cmd.advance = adv;
        return cmd;
    endfunction

    // top-level byte: wrap check first, then newline / return / escape / glyph
    function automatic tcec_pkg::cmd_t top_cmd(input logic [tcec_pkg::CHAR_W-1:0] c,
                                               input logic esc, input logic eos);
        tcec_pkg::cmd_t cmd;
        cmd      = '0;
        cmd.kind = tcec_pkg::CK_NONE;
        if (c == tcec_pkg::CH_NL)
        begin
            cmd.kind = tcec_pkg::CK_NL;
        end
        else if (c == tcec_pkg::CH_CR)
        begin
            cmd.kind = tcec_pkg::CK_CR;
        end
        else if (c == tcec_pkg::CH_BSL && esc)
        begin
            if (eos)
            begin
                cmd = draw_cmd(tcec_pkg::CH_BSL, 1'b1);
            end
        end
        else
        begin
            cmd = draw_cmd(c, 1'b1);
        end
        cmd.wrap = 1'b1;
        return cmd;
    endfunction

    assign src_c   = (state_reg == tcec_pkg::FS_IDLE) ? char_data.char_code
                                                      : rbuf_reg[ridx_reg[tcec_pkg::IDX_W-1:0]];
    assign src_eos = (state_reg == tcec_pkg::FS_IDLE) ? char_data.end_of_string
                                                      : (ridx_reg + 1'b1 == rlen_reg);
    assign src_esc = (state_reg == tcec_pkg::FS_IDLE) ? char_data.allow_escape : esc_reg;

    // colour from the five held digits and the one arriving now
    always_comb
    begin
        hex_color = '0;
        for (int i = 0; i < tcec_pkg::HEX_DIGITS; i++)
        begin
            if (i == tcec_pkg::HEX_DIGITS - 1)
            begin
                hex_color = {hex_color[tcec_pkg::COLOR_W-5:0], hex_val(src_c)};
            end
            else
            begin
                hex_color = {hex_color[tcec_pkg::COLOR_W-5:0], hex_val(hold_reg[i])};
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        count_next   = count_reg;
        ridx_next    = ridx_reg;
        rlen_next    = rlen_reg;
        cur_c_next   = cur_c_reg;
        cur_eos_next = cur_eos_reg;
        esc_next     = esc_reg;
        rep_next     = rep_reg;
        rep_base     = rep_reg;
        char_stall   = 1'b1;
        q_push       = 1'b0;
        q_cmd        = '0;
        do_byte      = 1'b0;
        go_top       = 1'b0;
        hold_we      = 1'b0;
        start_rep    = 1'b0;

        unique case (state_reg)
            tcec_pkg::FS_IDLE:
            begin
                char_stall = q_full;
                if (char_valid && !q_full)
                begin
                    do_byte   = 1'b1;
                    esc_next  = char_data.allow_escape;
                    rep_base  = '0;
                    ridx_next = '0;
                    rlen_next = '0;
                end
            end
            tcec_pkg::FS_TOP:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    q_cmd      = top_cmd(cur_c_reg, esc_reg, cur_eos_reg);
                    state_next = tcec_pkg::FS_NEXT;
                    if (cur_c_reg == tcec_pkg::CH_BSL && esc_reg && !cur_eos_reg)
                    begin
                        mode_next = tcec_pkg::PM_ESCAPE;
                    end
                end
            end
            tcec_pkg::FS_NEXT:
            begin
                if (!q_full)
                begin
                    if (ridx_reg < rlen_reg)
                    begin
                        do_byte   = 1'b1;
                        ridx_next = ridx_reg + 1'b1;
                    end
                    else
                    begin
                        q_push     = 1'b1;
                        q_cmd.kind = tcec_pkg::CK_END;
                        state_next = tcec_pkg::FS_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = tcec_pkg::FS_IDLE;
            end
        endcase

        if (do_byte)
        begin
            q_push = 1'b1;
            case (mode_reg)
                tcec_pkg::PM_ESCAPE:
                begin
                    mode_next = tcec_pkg::PM_NORMAL;
                    if (src_c == tcec_pkg::CH_BSL || src_c == tcec_pkg::CH_PCT ||
                        src_c == tcec_pkg::CH_LBR || src_c == tcec_pkg::CH_RBR)
                    begin
                        q_cmd = draw_cmd(src_c, 1'b1);
                    end
                    else if (src_c == tcec_pkg::CH_C)
                    begin
                        if (src_eos)
                        begin
                            q_cmd = draw_cmd(tcec_pkg::CH_QM, 1'b0);
                        end
                        else
                        begin
                            mode_next  = tcec_pkg::PM_HEX;
                            count_next = '0;
                        end
                    end
                    else
                    begin
                        // unknown escape: draw the backslash, then the byte at top level
                        q_cmd  = draw_cmd(tcec_pkg::CH_BSL, 1'b1);
                        go_top = 1'b1;
                    end
                end
                tcec_pkg::PM_HEX:
                begin
                    hold_we = 1'b1;
                    if (count_reg == tcec_pkg::CNT_W'(tcec_pkg::HEX_DIGITS - 1))
                    begin
                        q_cmd.kind  = tcec_pkg::CK_COLOR;
                        q_cmd.color = hex_color;
                        mode_next   = tcec_pkg::PM_NORMAL;
                        count_next  = '0;
                    end
                    else if (src_eos)
                    begin
                        q_cmd      = draw_cmd(tcec_pkg::CH_QM, 1'b0);
                        mode_next  = tcec_pkg::PM_NORMAL;
                        count_next = '0;
                        start_rep  = 1'b1;
                        ridx_next  = '0;
                        rlen_next  = count_reg + 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                default:
                begin
                    mode_next = tcec_pkg::PM_NORMAL;
                    q_cmd     = top_cmd(src_c, src_esc, src_eos);
                    if (src_c == tcec_pkg::CH_BSL && src_esc && !src_eos)
                    begin
                        mode_next = tcec_pkg::PM_ESCAPE;
                    end
                end
            endcase
            cur_c_next   = src_c;
            cur_eos_next = src_eos;
            state_next   = go_top ? tcec_pkg::FS_TOP : tcec_pkg::FS_NEXT;
        end

        // results past the per-word limit still move the cursor
        if (q_push && q_cmd.kind == tcec_pkg::CK_DRAW)
        begin
            q_cmd.report = (rep_base < tcec_pkg::REP_W'(tcec_pkg::MAX_RESULTS));
            rep_next     = q_cmd.report ? rep_base + 1'b1 : rep_base;
        end
        else
        begin
            rep_next = rep_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tcec_pkg::FS_IDLE;
            mode_reg    <= tcec_pkg::PM_NORMAL;
            count_reg   <= '0;
            ridx_reg    <= '0;
            rlen_reg    <= '0;
            rep_reg     <= '0;
            esc_reg     <= 1'b0;
            cur_eos_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            count_reg   <= count_next;
            ridx_reg    <= ridx_next;
            rlen_reg    <= rlen_next;
            rep_reg     <= rep_next;
            esc_reg     <= esc_next;
            cur_eos_reg <= cur_eos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_c_reg <= cur_c_next;
        if (hold_we)
        begin
            hold_reg[count_reg[tcec_pkg::IDX_W-1:0]] <= src_c;
        end
        if (start_rep)
        begin
            for (int i = 0; i < tcec_pkg::HEX_DIGITS; i++)
            begin
                rbuf_reg[i] <= (tcec_pkg::CNT_W'(i) == count_reg) ? src_c : hold_reg[i];
            end
        end
    end

endmodule

### src/tcec_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcec_back
// Cursor executor: applies queued commands to cursor and colour and
// delivers draw words, holding one back to mark the last of each character.
// ----------------------------------------------------------------------------
module tcec_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [tcec_pkg::X_W-1:0] cfg_data,
    input  logic                     q_valid,
    input  tcec_pkg::cmd_t           q_cmd,
    output logic                     q_pop,
    output logic                     draw_valid,
    input  logic                     draw_stall,
    output tcec_pkg::draw_word_t     draw_data
);

    logic [tcec_pkg::X_W-1:0]     width_reg;
    logic [tcec_pkg::X_W-1:0]     x_reg, x_next, x_wrap;
    logic [tcec_pkg::Y_W-1:0]     y_reg, y_next, y_wrap;
    logic [tcec_pkg::COLOR_W-1:0] color_reg, color_next;
    logic                         pend_valid_reg, pend_valid_next;
    tcec_pkg::draw_word_t         pend_reg, pend_next;
    logic                         out_valid_reg, out_valid_next;
    tcec_pkg::draw_word_t         out_reg, out_next;
    logic                         slot_free, need_out, wrap_hit;

    assign cfg_ready  = 1'b1;
    assign draw_valid = out_valid_reg;
    assign draw_data  = out_reg;

    assign slot_free = !out_valid_reg || !draw_stall;
    assign need_out  = pend_valid_reg &&
                       ((q_cmd.kind == tcec_pkg::CK_DRAW && q_cmd.report) ||
                        q_cmd.kind == tcec_pkg::CK_END);
    assign q_pop     = q_valid && (!need_out || slot_free);

    assign wrap_hit = q_cmd.wrap && (x_reg >= width_reg);
    assign x_wrap   = wrap_hit ? '0 : x_reg;
    assign y_wrap   = wrap_hit ? y_reg + tcec_pkg::Y_W'(tcec_pkg::LINE_HEIGHT) : y_reg;

    always_comb
    begin
        x_next          = x_reg;
        y_next          = y_reg;
        color_next      = color_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && draw_stall;
        out_next        = out_reg;

        if (q_pop)
        begin
            x_next = x_wrap;
            y_next = y_wrap;
            case (q_cmd.kind)
                tcec_pkg::CK_NL:
                begin
                    y_next = y_wrap + tcec_pkg::Y_W'(tcec_pkg::LINE_HEIGHT);
                end
                tcec_pkg::CK_CR:
                begin
                    x_next = '0;
                end
                tcec_pkg::CK_DRAW:
                begin
                    if (q_cmd.report)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_next          = pend_reg;
                            out_next.run_last = 1'b0;
                            out_valid_next    = 1'b1;
                        end
                        pend_next.pos_x      = x_wrap;
                        pend_next.pos_y      = y_wrap;
                        pend_next.glyph_code = q_cmd.glyph;
                        pend_next.draw_color = color_reg;
                        pend_next.run_last   = 1'b0;
                        pend_valid_next      = 1'b1;
                    end
                    if (q_cmd.advance)
                    begin
                        x_next = x_wrap + tcec_pkg::X_W'(tcec_pkg::GLYPH_WIDTH);
                    end
                end
                tcec_pkg::CK_COLOR:
                begin
                    color_next = q_cmd.color;
                end
                tcec_pkg::CK_END:
                begin
                    // held word is the last one of the character
                    if (pend_valid_reg)
                    begin
                        out_next          = pend_reg;
                        out_next.run_last = 1'b1;
                        out_valid_next    = 1'b1;
                        pend_valid_next   = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= tcec_pkg::WIDTH_RESET;
            x_reg          <= '0;
            y_reg          <= '0;
            color_reg      <= tcec_pkg::COLOR_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                width_reg <= cfg_data;
            end
            x_reg          <= x_next;
            y_reg          <= y_next;
            color_reg      <= color_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

endmodule

### src/text_console_escape_cursor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_escape_cursor_unit
// Text console front end: escape parsing, cursor tracking and colour state,
// producing glyph draw words.
// ----------------------------------------------------------------------------
// a new character is taken only once the last is classified and its end mark queued;
// an unknown escape adds a top-level step; a string ending inside a colour code adds
//   a replay of the held bytes, set by the parser's single byte step
// draw words pass through the command queue, a held slot and the output register
// reset: cursor at 0,0, colour all ones, screen width 1024, parser normal,
//   queue and output empty; no clearing pass
module text_console_escape_cursor_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tcec_pkg::X_W-1:0]       cfg_data,
    input  logic                           char_valid,
    output logic                           char_stall,
    input  tcec_pkg::char_word_t           char_data,
    output logic                           draw_valid,
    input  logic                           draw_stall,
    output tcec_pkg::draw_word_t           draw_data
);

    logic           f_push, q_full, q_valid, q_pop;
    tcec_pkg::cmd_t f_cmd, q_head;

    tcec_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data),
        .q_push     (f_push),
        .q_cmd      (f_cmd),
        .q_full     (q_full)
    );

    tcec_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (f_push),
        .push_cmd (f_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    tcec_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .q_valid    (q_valid),
        .q_cmd      (q_head),
        .q_pop      (q_pop),
        .draw_valid (draw_valid),
        .draw_stall (draw_stall),
        .draw_data  (draw_data)
    );

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for text_console_escape_cursor_unit. Text is fed as strings of
// character words: a directed opening for the escape and cursor corner cases,
// then random strings built mostly from well-formed tokens. A predictor in
// the bench turns each accepted word into the draw words it should cause,
// and every draw word leaving the block is checked against the oldest one.
// Screen width is changed between phases, and sender gaps and receiver
// stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [tcec_pkg::X_W-1:0] cfg_data = '0;
    logic       char_valid = 1'b0;
    logic       char_stall;
    tcec_pkg::char_word_t char_data = '0;
    logic       draw_valid;
    logic       draw_stall = 1'b0;
    tcec_pkg::draw_word_t draw_data;

    // stimulus side
    tcec_pkg::char_word_t text_queue [$];
    tcec_pkg::char_word_t str_q [$];
    logic       str_esc;
    logic       char_fire = 1'b0;
    int         chars_sent = 0;
    int         chars_taken = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    logic       hold_req = 1'b0;
    string      hex_set = "0123456789abcdefABCDEF";

    // predicted block state
    logic [tcec_pkg::X_W-1:0]     width_reg = tcec_pkg::WIDTH_RESET;
    logic [tcec_pkg::X_W-1:0]     cur_x = '0;
    logic [tcec_pkg::Y_W-1:0]     cur_y = '0;
    logic [tcec_pkg::COLOR_W-1:0] color = tcec_pkg::COLOR_RESET;
    tcec_pkg::parse_mode_t        esc_state = tcec_pkg::PM_NORMAL;
    logic [tcec_pkg::CHAR_W-1:0]  hex_held [tcec_pkg::HEX_DIGITS];
    int                           hex_cnt = 0;
    tcec_pkg::draw_word_t         step_draws [$];
    tcec_pkg::draw_word_t         draws_due [$];

    int cycle_count = 0;
    int fail_count = 0;

    text_console_escape_cursor_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data),
        .draw_valid (draw_valid),
        .draw_stall (draw_stall),
        .draw_data  (draw_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [3:0] hex_nibble(input logic [tcec_pkg::CHAR_W-1:0] c);
        if (c >= tcec_pkg::CH_0 && c <= tcec_pkg::CH_9)
            return 4'(c - tcec_pkg::CH_0);
        if (c >= tcec_pkg::CH_LA && c <= tcec_pkg::CH_LF)
            return 4'(c - tcec_pkg::CH_LA + 8'd10);
        if (c >= tcec_pkg::CH_UA && c <= tcec_pkg::CH_UF)
            return 4'(c - tcec_pkg::CH_UA + 8'd10);
        return 4'd0;
    endfunction

    task automatic put_glyph(input logic [tcec_pkg::CHAR_W-1:0] g);
        tcec_pkg::draw_word_t d;
        d.pos_x      = cur_x;
        d.pos_y      = cur_y;
        d.glyph_code = g;
        d.draw_color = color;
        d.run_last   = 1'b0;
        if (step_draws.size() < tcec_pkg::MAX_RESULTS)
            step_draws.push_back(d);
    endtask

    task automatic step_x;
        cur_x = cur_x + tcec_pkg::X_W'(tcec_pkg::GLYPH_WIDTH);
    endtask

    task automatic top_char(input logic [tcec_pkg::CHAR_W-1:0] c, input logic esc,
                            input logic eos);
        if (cur_x >= width_reg)
        begin
            cur_x = '0;
            cur_y = cur_y + tcec_pkg::Y_W'(tcec_pkg::LINE_HEIGHT);
        end
        if (c == tcec_pkg::CH_NL)
            cur_y = cur_y + tcec_pkg::Y_W'(tcec_pkg::LINE_HEIGHT);
        else if (c == tcec_pkg::CH_CR)
            cur_x = '0;
        else if (c == tcec_pkg::CH_BSL && esc)
        begin
            if (eos)
            begin
                put_glyph(tcec_pkg::CH_BSL);
                step_x();
            end
            else
                esc_state = tcec_pkg::PM_ESCAPE;
        end
        else
        begin
            put_glyph(c);
            step_x();
        end
    endtask

    task automatic render_char(input tcec_pkg::char_word_t w);
        logic [tcec_pkg::CHAR_W-1:0]  work_c [$];
        logic                         work_eos [$];
        logic [tcec_pkg::CHAR_W-1:0]  c;
        logic                         eos;
        logic                         esc;
        logic [tcec_pkg::COLOR_W-1:0] v;
        tcec_pkg::draw_word_t         d;
        int                           k;
        int                           i;
        esc = w.allow_escape;
        step_draws.delete();
        work_c.push_back(w.char_code);
        work_eos.push_back(w.end_of_string);
        // a string ending inside a colour code replays the held bytes through here
        while (work_c.size() > 0)
        begin
            c   = work_c.pop_front();
            eos = work_eos.pop_front();
            case (esc_state)
                tcec_pkg::PM_ESCAPE:
                begin
                    esc_state = tcec_pkg::PM_NORMAL;
                    if (c == tcec_pkg::CH_BSL || c == tcec_pkg::CH_PCT ||
                        c == tcec_pkg::CH_LBR || c == tcec_pkg::CH_RBR)
                    begin
                        put_glyph(c);
                        step_x();
                    end
                    else if (c == tcec_pkg::CH_C)
                    begin
                        if (eos)
                            put_glyph(tcec_pkg::CH_QM);
                        else
                        begin
                            esc_state = tcec_pkg::PM_HEX;
                            hex_cnt = 0;
                        end
                    end
                    else
                    begin
                        put_glyph(tcec_pkg::CH_BSL);
                        step_x();
                        top_char(c, esc, eos);
                    end
                end
                tcec_pkg::PM_HEX:
                begin
                    hex_held[hex_cnt] = c;
                    hex_cnt++;
                    if (hex_cnt >= tcec_pkg::HEX_DIGITS)
                    begin
                        v = '0;
                        for (i = 0; i < tcec_pkg::HEX_DIGITS; i++)
                            v = (v << 4) | tcec_pkg::COLOR_W'(hex_nibble(hex_held[i]));
                        color = v;
                        esc_state = tcec_pkg::PM_NORMAL;
                        hex_cnt = 0;
                    end
                    else if (eos)
                    begin
                        k = hex_cnt;
                        esc_state = tcec_pkg::PM_NORMAL;
                        hex_cnt = 0;
                        put_glyph(tcec_pkg::CH_QM);
                        for (i = 0; i < k; i++)
                        begin
                            work_c.push_back(hex_held[i]);
                            work_eos.push_back(i == k - 1);
                        end
                    end
                end
                default:
                begin
                    esc_state = tcec_pkg::PM_NORMAL;
                    top_char(c, esc, eos);
                end
            endcase
        end
        for (i = 0; i < step_draws.size(); i++)
        begin
            d = step_draws[i];
            d.run_last = (i == step_draws.size() - 1);
            draws_due.push_back(d);
        end
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic note_field(input string name, input longint unsigned want,
                              input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_draw(input tcec_pkg::draw_word_t got);
        tcec_pkg::draw_word_t want;
        if (draws_due.size() == 0)
        begin
            $display("%0t: draw word with none expected, expected nothing got %h",
                     $time, got);
            fail_count++;
        end
        else
        begin
            want = draws_due.pop_front();
            note_field("pos_x", want.pos_x, got.pos_x);
            note_field("pos_y", want.pos_y, got.pos_y);
            note_field("glyph_code", want.glyph_code, got.glyph_code);
            note_field("draw_color", want.draw_color, got.draw_color);
            note_field("run_last", want.run_last, got.run_last);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
        else if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                width_reg = cfg_data;
            char_fire <= char_valid && !char_stall;
            if (char_valid && !char_stall)
            begin
                render_char(char_data);
                chars_taken++;
            end
            if (draw_valid && !draw_stall)
                check_draw(draw_data);
        end
    end

    // ------------------------------------------------------------------
    // driver and receiver
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!char_valid || char_fire))
        begin
            if (text_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                char_valid <= 1'b1;
                char_data  <= text_queue.pop_front();
            end
            else
                char_valid <= 1'b0;
        end
    end

    int   hold_left = 0;
    logic hold_done = 1'b0;

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            draw_stall <= 1'b1;
        end
        else if (hold_req && !hold_done)
        begin
            // long hold-off so the block backs up and stalls its input
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            draw_stall <= 1'b1;
        end
        else
            draw_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic push_char(input tcec_pkg::char_word_t w);
        text_queue.push_back(w);
        chars_sent++;
    endtask

    task automatic put_char(input logic [tcec_pkg::CHAR_W-1:0] c, input logic esc,
                            input logic eos);
        tcec_pkg::char_word_t w;
        w.char_code     = c;
        w.allow_escape  = esc;
        w.end_of_string = eos;
        push_char(w);
    endtask

    task automatic put_text(input string s, input logic esc);
        int i;
        for (i = 0; i < s.len(); i++)
            put_char(s[i], esc, i == s.len() - 1);
    endtask

    task automatic add_byte(input logic [tcec_pkg::CHAR_W-1:0] c);
        tcec_pkg::char_word_t w;
        w.char_code     = c;
        w.allow_escape  = ($urandom_range(0, 19) == 0) ? !str_esc : str_esc;
        w.end_of_string = 1'b0;
        str_q.push_back(w);
    endtask

    function automatic logic [tcec_pkg::CHAR_W-1:0] hex_char();
        if ($urandom_range(0, 9) == 0)
            return tcec_pkg::CHAR_W'($urandom_range(0, 255));
        return hex_set[$urandom_range(0, 21)];
    endfunction

    function automatic logic [tcec_pkg::CHAR_W-1:0] plain_escape();
        case ($urandom_range(0, 3))
            0: return tcec_pkg::CH_BSL;
            1: return tcec_pkg::CH_PCT;
            2: return tcec_pkg::CH_LBR;
            default: return tcec_pkg::CH_RBR;
        endcase
    endfunction

    // bytes held in a cut-off colour code; escapes in them matter on replay
    function automatic logic [tcec_pkg::CHAR_W-1:0] held_noise();
        case ($urandom_range(0, 4))
            0: return tcec_pkg::CH_BSL;
            1: return tcec_pkg::CH_C;
            2: return tcec_pkg::CH_NL;
            3: return hex_char();
            default: return tcec_pkg::CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic gen_string;
        tcec_pkg::char_word_t w;
        int tokens;
        int kind;
        int n;
        int i;
        str_esc = ($urandom_range(0, 3) != 0);
        tokens = $urandom_range(1, 6);
        for (i = 0; i < tokens; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
                add_byte(tcec_pkg::CHAR_W'($urandom_range(8'h20, 8'h7e)));
            else if (kind < 42)
                add_byte(tcec_pkg::CHAR_W'($urandom_range(0, 255)));
            else if (kind < 50)
                add_byte(($urandom_range(0, 1) != 0) ? tcec_pkg::CH_NL : tcec_pkg::CH_CR);
            else if (kind < 65)
            begin
                add_byte(tcec_pkg::CH_BSL);
                add_byte(plain_escape());
            end
            else if (kind < 80)
            begin
                add_byte(tcec_pkg::CH_BSL);
                add_byte(tcec_pkg::CH_C);
                repeat (tcec_pkg::HEX_DIGITS) add_byte(hex_char());
            end
            else
            begin
                add_byte(tcec_pkg::CH_BSL);
                add_byte(tcec_pkg::CHAR_W'($urandom_range(0, 255)));
            end
        end
        // some strings stop partway into an escape
        kind = $urandom_range(0, 99);
        if (kind < 8)
            add_byte(tcec_pkg::CH_BSL);
        else if (kind < 14)
        begin
            add_byte(tcec_pkg::CH_BSL);
            add_byte(tcec_pkg::CH_C);
        end
        else if (kind < 30)
        begin
            add_byte(tcec_pkg::CH_BSL);
            add_byte(tcec_pkg::CH_C);
            n = $urandom_range(1, tcec_pkg::HEX_DIGITS - 1);
            repeat (n) add_byte(($urandom_range(0, 2) == 0) ? held_noise() : hex_char());
        end
        w = str_q.pop_back();
        w.end_of_string = 1'b1;
        str_q.push_back(w);
        while (str_q.size() > 0)
            push_char(str_q.pop_front());
    endtask

    task automatic run_random(input int count);
        int start;
        start = chars_sent;
        while (chars_sent - start < count)
            gen_string();
    endtask

    task automatic wait_drained;
        do
            @(negedge clk);
        while (chars_taken != chars_sent || draws_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_width(input logic [tcec_pkg::X_W-1:0] w);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    initial
    begin
        int i;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed opening at the reset width
        put_text("\\}\\C1a2B3c\\q\\", 1'b1);
        put_char(8'h00, 1'b0, 1'b0);
        put_char(tcec_pkg::CH_NL, 1'b0, 1'b0);
        put_char(tcec_pkg::CH_CR, 1'b0, 1'b0);
        put_char(tcec_pkg::CH_BSL, 1'b0, 1'b0);
        put_char(8'hff, 1'b0, 1'b1);
        put_text("\\%\\{\\C", 1'b1);
        // escape begun with escapes on, finished with them off; odd digits
        put_char(tcec_pkg::CH_BSL, 1'b1, 1'b0);
        put_text("CzZ9fF", 1'b0);
        // cut-off colour code whose replay draws the most words
        put_text("\\C\\q\\qa", 1'b1);
        put_text("\\C1\\C", 1'b1);
        wait_drained();

        set_width(13'd4096);
        run_random(50);
        hold_req = 1'b1;
        wait_drained();

        set_width(13'd1);
        set_idling(58, 0);
        run_random(50);
        wait_drained();

        set_width(tcec_pkg::X_W'($urandom_range(8, 160)));
        set_idling(0, 58);
        run_random(50);
        wait_drained();

        // zero width wraps every top-level byte
        set_width(13'd0);
        set_idling(0, 0);
        put_text("ab\\C", 1'b1);
        for (i = 0; i < 8; i++)
            put_char(tcec_pkg::CH_NL, 1'b1, 1'b0);
        put_text("ok", 1'b1);
        run_random(30);
        wait_drained();

        set_width(tcec_pkg::X_W'($urandom_range(1, 4096)));
        set_idling(17, 17);
        run_random(50);
        wait_drained();

        set_width(13'd24);
        set_idling(0, 0);
        run_random(50);
        wait_drained();

        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
